@@ sv/rc_pkg.sv @@
package rc_pkg;

	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int STORE_DEPTH        = 32;
	localparam int QUEUE_DEPTH        = 2;
	localparam int DIV_RADIX_BITS     = 4;   // quotient bits resolved per cycle
	localparam int BASE_W             = 5;
	localparam int DIGIT_W            = 4;
	localparam int CHAR_W             = 8;
	localparam int APB_DATA_W         = 32;
	localparam int APB_ADDR_W         = 3;

	localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
	localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

	localparam logic [0:0] REG_SOURCE_BASE = 1'b0;
	localparam logic [0:0] REG_TARGET_BASE = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_0   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9   = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_F   = 8'h46;
	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] TEN      = 8'd10;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BASE     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic KIND_ERR  = 1'b0;
	localparam logic KIND_CONV = 1'b1;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_char;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last_digit;
		logic [1:0]        status;
	} out_item_t;

	// command handed from the front end to the converter
	typedef struct packed {
		logic       kind;
		logic [1:0] status;
	} cmd_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		if (b < BASE_MIN)
			r = BASE_MIN;
		else if (b > BASE_MAX)
			r = BASE_MAX;
		else
			r = b;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (CHAR_W'(d) < TEN)
			c = CHAR_0 + CHAR_W'(d);
		else
			c = CHAR_A + CHAR_W'(d) - TEN;
		return c;
	endfunction

endpackage

@@ sv/radix_converter.sv @@
// A digit item is taken while the queue has room; the value goes to the converter through
// a two-entry queue. Throughput: one digit item per cycle while the queue has room.
// Conversion: the shared divider works out each output digit in DIV_RADIX_BITS-bit steps,
// then each digit is read from the digit store and loaded into the output register.
// Reset clears the accumulator, the error flag, the queue and the converter; both
// bases return to 10. The digit store is not cleared.
module radix_converter #(
	parameter int VALUE_BITS = rc_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          digit_valid,
	output logic                          digit_stall,
	input  rc_pkg::in_item_t              digit_item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output rc_pkg::out_item_t             result_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rc_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready
);

	import rc_pkg::*;

	localparam int Q_W = $bits(cmd_t) + VALUE_BITS;

	logic [BASE_W-1:0]     src_base_q, tgt_base_q;
	logic [BASE_W-1:0]     sb, tb;
	logic                  q_full, q_valid, q_pop, push;
	cmd_t                  push_cmd, q_cmd;
	logic [VALUE_BITS-1:0] push_value, q_value;
	logic [Q_W-1:0]        q_rd_data;
	logic [0:0]            reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= BASE_RESET;
			tgt_base_q <= BASE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SOURCE_BASE: src_base_q <= pwdata[BASE_W-1:0];
				REG_TARGET_BASE: tgt_base_q <= pwdata[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SOURCE_BASE: prdata = APB_DATA_W'(src_base_q);
			REG_TARGET_BASE: prdata = APB_DATA_W'(tgt_base_q);
			default:         prdata = '0;
		endcase
	end

	assign sb          = clamp_base(src_base_q);
	assign tb          = clamp_base(tgt_base_q);
	assign digit_stall = q_full;

	rc_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (digit_valid),
		.in_item   (digit_item),
		.sb        (sb),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_value(push_value)
	);

	rc_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_cmd, push_value}),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_data (q_rd_data)
	);

	assign q_cmd   = q_rd_data[Q_W-1:VALUE_BITS];
	assign q_value = q_rd_data[VALUE_BITS-1:0];

	rc_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tb       (tb),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_value  (q_value),
		.q_pop    (q_pop),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_item (result_item)
	);

endmodule

@@ sv/rc_ram.sv @@
module rc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/rc_queue.sv @@
module rc_queue #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign valid    = count_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ sv/rc_front.sv @@
module rc_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  rc_pkg::in_item_t              in_item,
	input  logic [rc_pkg::BASE_W-1:0]     sb,
	input  logic                          q_full,
	output logic                          push,
	output rc_pkg::cmd_t                  push_cmd,
	output logic [VALUE_BITS-1:0]         push_value
);

	import rc_pkg::*;

	localparam int PROD_W = VALUE_BITS + BASE_W;

	logic [VALUE_BITS-1:0] acc_q;
	logic [1:0]            err_q;
	logic                  accept;
	logic [DIGIT_W-1:0]    digit;
	logic                  unknown;
	logic [PROD_W-1:0]     prod;
	logic [1:0]            st;

	assign accept = in_valid && !q_full;

	always_comb begin
		digit   = '0;
		unknown = 1'b0;
		if (in_item.digit_char >= CHAR_0 && in_item.digit_char <= CHAR_9)
			digit = DIGIT_W'(in_item.digit_char - CHAR_0);
		else if (in_item.digit_char >= CHAR_A && in_item.digit_char <= CHAR_F)
			digit = DIGIT_W'(in_item.digit_char - CHAR_A + TEN);
		else
			unknown = 1'b1;
	end

	// Horner step; anything above the value width is an overflow
	assign prod = PROD_W'(acc_q) * PROD_W'(sb) + PROD_W'(digit);

	always_comb begin
		if (unknown)
			st = ST_UNKNOWN;
		else if (BASE_W'(digit) >= sb)
			st = ST_BASE;
		else if (prod[PROD_W-1:VALUE_BITS] != '0)
			st = ST_OVERFLOW;
		else
			st = ST_OK;
	end

	assign push       = accept && err_q == ST_OK && (st != ST_OK || in_item.last_char);
	assign push_cmd   = '{kind: (st == ST_OK) ? KIND_CONV : KIND_ERR, status: st};
	assign push_value = prod[VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= ST_OK;
		end else if (accept) begin
			if (in_item.last_char) begin
				acc_q <= '0;
				err_q <= ST_OK;
			end else if (err_q == ST_OK) begin
				if (st == ST_OK)
					acc_q <= prod[VALUE_BITS-1:0];
				else
					err_q <= st;
			end
		end
	end

endmodule

@@ sv/rc_back.sv @@
module rc_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rc_pkg::BASE_W-1:0] tb,
	input  logic                      q_valid,
	input  rc_pkg::cmd_t              q_cmd,
	input  logic [VALUE_BITS-1:0]     q_value,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rc_pkg::out_item_t         out_item
);

	import rc_pkg::*;

	localparam int DIV_STEPS = (VALUE_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
	localparam int DIV_W     = DIV_STEPS * DIV_RADIX_BITS;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W     = $clog2(STORE_DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DIV    = 3'd1;
	localparam logic [2:0] S_OUT_RD = 3'd2;
	localparam logic [2:0] S_OUT_WR = 3'd3;
	localparam logic [2:0] S_ERR    = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STEP_W-1:0]  step_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [1:0]         err_st_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic [DIV_W-1:0]   div_nx;
	logic [DIGIT_W-1:0] rem_nx;
	logic [DIGIT_W:0]   r_w;
	logic [DIV_W-1:0]   q_w;
	logic               last_step;
	logic               out_free;
	logic [CNT_W-1:0]   cnt_inc, cnt_dec;
	logic               wr_en, rd_en;
	logic [DIGIT_W-1:0] rd_data;
	logic               load_err, load_dig;

	// restoring division by the target base, DIV_RADIX_BITS quotient bits per cycle
	always_comb begin
		r_w = {1'b0, rem_q};
		q_w = div_q;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			r_w = {r_w[DIGIT_W-1:0], q_w[DIV_W-1]};
			q_w = {q_w[DIV_W-2:0], 1'b0};
			if (r_w >= tb) begin
				r_w    = r_w - tb;
				q_w[0] = 1'b1;
			end
		end
		rem_nx = r_w[DIGIT_W-1:0];
		div_nx = q_w;
	end

	assign last_step = step_q == STEP_W'(DIV_STEPS - 1);
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_inc   = cnt_q + 1'b1;
	assign cnt_dec   = cnt_q - 1'b1;
	assign q_pop     = state_q == S_IDLE && q_valid;
	assign wr_en     = state_q == S_DIV && last_step;
	assign rd_en     = state_q == S_OUT_RD;
	assign load_err  = state_q == S_ERR && out_free;
	assign load_dig  = state_q == S_OUT_WR && out_free;

	rc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(cnt_q[IDX_W-1:0]),
		.wr_data(rem_nx),
		.rd_en  (rd_en),
		.rd_addr(cnt_dec[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_err || load_dig)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cnt_q  <= '0;
						step_q <= '0;
						state_q <= (q_cmd.kind == KIND_CONV) ? S_DIV : S_ERR;
					end
				end
				S_DIV: begin
					if (last_step) begin
						step_q <= '0;
						cnt_q  <= cnt_inc;
						if (div_nx == '0)
							state_q <= S_OUT_RD;
						else if (cnt_inc == CNT_W'(STORE_DEPTH))
							state_q <= S_ERR;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_OUT_RD: state_q <= S_OUT_WR;
				S_OUT_WR: begin
					if (out_free) begin
						cnt_q   <= cnt_dec;
						state_q <= (cnt_q == CNT_W'(1)) ? S_IDLE : S_OUT_RD;
					end
				end
				S_ERR: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			div_q    <= DIV_W'(q_value);
			rem_q    <= '0;
			err_st_q <= q_cmd.status;
		end else if (state_q == S_DIV) begin
			if (last_step) begin
				div_q    <= div_nx;
				rem_q    <= '0;
				err_st_q <= ST_OVERFLOW;
			end else begin
				div_q <= div_nx;
				rem_q <= rem_nx;
			end
		end

		if (load_err)
			out_item_q <= '{out_char: CHAR_NUL, last_digit: 1'b1, status: err_st_q};
		else if (load_dig)
			out_item_q <= '{out_char: digit_to_char(rd_data),
				last_digit: cnt_q == CNT_W'(1), status: ST_OK};
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ tb/radix_converter_tb.sv @@
`timescale 1ns / 1ps

module radix_converter_tb;
	import rc_pkg::*;

	localparam int VB = DEFAULT_VALUE_BITS;
	localparam longint unsigned VALUE_MAX = (64'd1 << VB) - 64'd1;
	localparam logic [APB_ADDR_W-1:0] ADDR_SOURCE = {REG_SOURCE_BASE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_TARGET = {REG_TARGET_BASE, 2'b00};
	// worst conversion: 32 digits through the divider plus readout, with margin
	localparam int SETTLE_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS = 38;
	localparam int NUM_PHASES = 8;

	typedef enum logic {ROW_DIGIT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		in_item_t                item;
		bit                      typed;
		out_item_t               want;
		logic [APB_ADDR_W-1:0]   addr;
		logic [BASE_W-1:0]       radix;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic digit_valid;
	logic digit_stall;
	in_item_t digit_item;
	logic result_valid;
	logic result_stall;
	out_item_t result_item;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// shadow of the block
	logic [BASE_W-1:0] src_radix;
	logic [BASE_W-1:0] dst_radix;
	logic [VB-1:0] acc_value;
	logic [1:0] sticky_err;

	out_item_t pending_results[$];
	row_t plan[$];
	int fail_count = 0;
	int quiet_cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	radix_converter #(.VALUE_BITS(VB)) DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [BASE_W-1:0] effective_radix(logic [BASE_W-1:0] r);
		return (r < BASE_MIN) ? BASE_MIN : ((r > BASE_MAX) ? BASE_MAX : r);
	endfunction

	function automatic logic [CHAR_W-1:0] ascii_of(logic [DIGIT_W-1:0] d);
		return (d < 4'd10) ? CHAR_0 + CHAR_W'(d) : CHAR_A + CHAR_W'(d) - TEN;
	endfunction

	task automatic predict_digit(input in_item_t it, output out_item_t res[$]);
		logic [BASE_W-1:0] sb;
		logic [BASE_W-1:0] tb;
		logic [DIGIT_W-1:0] d;
		logic [1:0] st;
		longint unsigned grown;
		longint unsigned v;
		logic [DIGIT_W-1:0] rev[STORE_DEPTH];
		int cnt;
		res = {};
		sb = effective_radix(src_radix);
		tb = effective_radix(dst_radix);
		// rest of a failed number is swallowed up to its last item
		if (sticky_err != ST_OK) begin
			if (it.last_char) begin
				acc_value = '0;
				sticky_err = ST_OK;
			end
			return;
		end
		st = ST_OK;
		d = '0;
		if (it.digit_char >= CHAR_0 && it.digit_char <= CHAR_9)
			d = DIGIT_W'(it.digit_char - CHAR_0);
		else if (it.digit_char >= CHAR_A && it.digit_char <= CHAR_F)
			d = DIGIT_W'(it.digit_char - CHAR_A + TEN);
		else
			st = ST_UNKNOWN;
		grown = 64'(acc_value) * 64'(sb) + 64'(d);
		if (st == ST_OK && d >= sb)
			st = ST_BASE;
		if (st == ST_OK && grown > VALUE_MAX)
			st = ST_OVERFLOW;
		if (st != ST_OK) begin
			res.push_back('{out_char: CHAR_NUL, last_digit: 1'b1, status: st});
			if (it.last_char) begin
				acc_value = '0;
				sticky_err = ST_OK;
			end else begin
				sticky_err = st;
			end
			return;
		end
		acc_value = grown[VB-1:0];
		if (!it.last_char)
			return;
		v = 64'(acc_value);
		cnt = 0;
		if (v == 0) begin
			rev[0] = '0;
			cnt = 1;
		end
		while (v != 0 && cnt < STORE_DEPTH) begin
			rev[cnt] = DIGIT_W'(v % 64'(tb));
			v = v / 64'(tb);
			cnt++;
		end
		acc_value = '0;
		sticky_err = ST_OK;
		if (v != 0) begin
			res.push_back('{out_char: CHAR_NUL, last_digit: 1'b1, status: ST_OVERFLOW});
			return;
		end
		for (int k = cnt - 1; k >= 0; k--)
			res.push_back('{out_char: ascii_of(rev[k]), last_digit: (k == 0), status: ST_OK});
	endtask

	function automatic void plan_digit(logic [CHAR_W-1:0] ch, logic last);
		row_t r;
		r.kind = ROW_DIGIT;
		r.item = '{digit_char: ch, last_char: last};
		r.typed = 1'b0;
		r.want = '0;
		r.addr = '0;
		r.radix = '0;
		plan.push_back(r);
	endfunction

	// all hand-written expectations are single error or single-digit items
	function automatic void plan_checked(logic [CHAR_W-1:0] ch, logic last,
			logic [CHAR_W-1:0] oc, logic [1:0] st);
		row_t r;
		r.kind = ROW_DIGIT;
		r.item = '{digit_char: ch, last_char: last};
		r.typed = 1'b1;
		r.want = '{out_char: oc, last_digit: 1'b1, status: st};
		r.addr = '0;
		r.radix = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_write(logic [APB_ADDR_W-1:0] addr, logic [BASE_W-1:0] radix);
		row_t r;
		r.kind = ROW_WRITE;
		r.item = '0;
		r.typed = 1'b0;
		r.want = '0;
		r.addr = addr;
		r.radix = radix;
		plan.push_back(r);
	endfunction

	task automatic drain_results();
		digit_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		// non-last items leave no trace, so give the block time to go idle
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_radix(logic [APB_ADDR_W-1:0] addr, logic [BASE_W-1:0] radix);
		logic [APB_DATA_W-1:0] word;
		drain_results();
		word = ($urandom() & ~APB_DATA_W'(32'h1F)) | APB_DATA_W'(radix);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_SOURCE)
			src_radix = word[BASE_W-1:0];
		else
			dst_radix = word[BASE_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_digit(in_item_t it, bit typed, out_item_t want);
		out_item_t got[$];
		if ($urandom_range(0, 99) < gap_pct) begin
			digit_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		digit_item <= it;
		digit_valid <= 1'b1;
		@(posedge clk);
		while (digit_stall)
			@(posedge clk);
		predict_digit(it, got);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (got[i])
				pending_results.push_back(got[i]);
		@(negedge clk);
	endtask

	// one number: mostly well-formed, some noise, overflow runs, zeros, bad digits
	task automatic send_number(inout int made);
		logic [BASE_W-1:0] sb;
		longint unsigned v;
		int maxd;
		int len;
		int kind;
		int bad_at;
		logic [DIGIT_W-1:0] d;
		in_item_t it;
		sb = effective_radix(src_radix);
		v = VALUE_MAX;
		maxd = 0;
		while (v != 0) begin
			v = v / 64'(sb);
			maxd++;
		end
		kind = $urandom_range(0, 15);
		case (kind)
			0, 1: len = $urandom_range(1, 4);
			2: len = maxd + $urandom_range(1, 3);
			3: len = $urandom_range(1, 3);
			default: len = $urandom_range(1, maxd);
		endcase
		bad_at = (kind == 4) ? $urandom_range(0, len - 1) : -1;
		for (int i = 0; i < len; i++) begin
			d = DIGIT_W'($urandom_range(0, sb - 1));
			if (kind == 2 && i == 0)
				d = DIGIT_W'(sb - 1);
			if (kind == 3)
				d = '0;
			it.digit_char = ascii_of(d);
			if (kind <= 1)
				it.digit_char = CHAR_W'($urandom());
			else if (i == bad_at)
				it.digit_char = (sb < BASE_MAX) ? ascii_of(DIGIT_W'($urandom_range(sb, 15)))
					: CHAR_F + CHAR_W'($urandom_range(1, 26));
			else if ($urandom_range(0, 39) == 0)
				it.digit_char = CHAR_W'($urandom());
			it.last_char = (i == len - 1) || (kind <= 1 && $urandom_range(0, 7) == 0);
			send_digit(it, 1'b0, '0);
			made++;
		end
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result item %h", result_item);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_item.out_char !== want.out_char) begin
					$error("out_char: expected %h, got %h", want.out_char, result_item.out_char);
					fail_count++;
				end
				if (result_item.last_digit !== want.last_digit) begin
					$error("last_digit: expected %b, got %b", want.last_digit,
						result_item.last_digit);
					fail_count++;
				end
				if (result_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_item.status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (digit_valid && !digit_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		int run;
		result_stall = 1'b0;
		forever begin
			run = $urandom_range(1, 17);
			result_stall <= ($urandom_range(0, 99) < stall_pct);
			repeat (run) @(negedge clk);
		end
	end

	initial begin
		int made;
		logic [BASE_W-1:0] sb_pick;
		logic [BASE_W-1:0] tb_pick;
		arst_n = 1'b0;
		digit_valid = 1'b0;
		digit_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_radix = BASE_RESET;
		dst_radix = BASE_RESET;
		acc_value = '0;
		sticky_err = ST_OK;

		// reset bases are 10/10
		plan_checked(CHAR_0, 1'b1, CHAR_0, ST_OK);
		plan_checked(CHAR_9, 1'b1, CHAR_9, ST_OK);
		plan_checked(CHAR_A, 1'b1, CHAR_NUL, ST_BASE);
		plan_checked(8'h00, 1'b1, CHAR_NUL, ST_UNKNOWN);
		plan_checked(8'hFF, 1'b1, CHAR_NUL, ST_UNKNOWN);
		// error mid-number, then the last item is swallowed
		plan_digit(CHAR_0 + 8'd1, 1'b0);
		plan_checked(CHAR_9 + 8'd1, 1'b0, CHAR_NUL, ST_UNKNOWN);
		plan_digit(CHAR_0 + 8'd5, 1'b1);
		plan_write(ADDR_SOURCE, BASE_MAX);
		plan_write(ADDR_TARGET, BASE_MIN);
		// largest value: 32 binary ones
		for (int i = 0; i < 8; i++)
			plan_digit(CHAR_F, i == 7);
		// one hex digit too many
		for (int i = 0; i < 8; i++)
			plan_digit(CHAR_F, 1'b0);
		plan_checked(CHAR_0, 1'b1, CHAR_NUL, ST_OVERFLOW);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_pct = 30;
		stall_pct = 30;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_radix(plan[i].addr, plan[i].radix);
			else
				send_digit(plan[i].item, plan[i].typed, plan[i].want);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin sb_pick = BASE_MIN; tb_pick = BASE_MAX; end
				1: begin sb_pick = BASE_MAX; tb_pick = BASE_MIN; end
				2: begin sb_pick = 5'd0; tb_pick = 5'd31; end
				3: begin sb_pick = 5'd1; tb_pick = 5'd17; end
				default: begin
					sb_pick = BASE_W'($urandom_range(0, 31));
					tb_pick = BASE_W'($urandom_range(0, 31));
				end
			endcase
			write_radix(ADDR_SOURCE, sb_pick);
			write_radix(ADDR_TARGET, tb_pick);
			if (phase == NUM_PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 25;
					default: stall_pct = 50;
				endcase
			end
			made = 0;
			while (made < PHASE_ITEMS)
				send_number(made);
		end

		drain_results();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/rc_pkg.sv
sv/rc_ram.sv
sv/rc_queue.sv
sv/rc_front.sv
sv/rc_back.sv
sv/radix_converter.sv
tb/radix_converter_tb.sv
